/* design/cac_pkg.sv */
// shared types and constants for the cell averaging cfar threshold block
package cac_pkg;

	localparam int WIN_DEPTH  = 64;
	localparam int WIN_AW     = $clog2(WIN_DEPTH);
	localparam int MAX_REF    = 16;
	localparam int MAX_GUARD  = 8;
	localparam int CMDQ_DEPTH = 4;
	localparam int SUM_W      = 37;
	localparam int THR_W      = 40;

	// configuration register indexes
	localparam logic [1:0] CFG_REF   = 2'd0;
	localparam logic [1:0] CFG_GUARD = 2'd1;
	localparam logic [1:0] CFG_ALPHA = 2'd2;

	typedef struct packed {
		logic signed [15:0] bin_real;
		logic signed [15:0] bin_imag;
		logic               frame_last;
	} bin_t;

	typedef struct packed {
		logic [31:0]      cell_power;
		logic [THR_W-1:0] noise_threshold;
		logic             cell_last;
	} cell_t;

	// clamped settings shared by front and back
	typedef struct packed {
		logic [4:0]  rc;
		logic [3:0]  gc;
		logic [15:0] alpha;
	} cfg_t;

	// one cell to emit: window slot, cells in frame before and after it
	typedef struct packed {
		logic [WIN_AW-1:0] pos;
		logic [5:0]        lavail;
		logic [5:0]        ravail;
		logic              last;
	} cmd_t;

endpackage

/* design/cac_ram.sv */
// generic single write, single read ram with registered read data
module cac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* design/cac_cmd_fifo.sv */
// short command queue between front and back
module cac_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cac_pkg::cmd_t  din,
	output logic           full,
	input  logic           pop,
	output cac_pkg::cmd_t  dout,
	output logic           empty
);
	import cac_pkg::*;
	localparam int AW = $clog2(CMDQ_DEPTH);

	cmd_t          mem_q [CMDQ_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(CMDQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop)  rp_q <= rp_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= din;
	end
endmodule

/* design/cac_front.sv */
// front: accepts bins, squares them into the window, issues emit commands
module cac_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cac_pkg::cfg_t              cfg,
	input  logic                       push,
	input  cac_pkg::bin_t              bin,
	output logic                       full,
	output logic                       ram_we,
	output logic [cac_pkg::WIN_AW-1:0] ram_waddr,
	output logic [31:0]                ram_wdata,
	output logic                       cmd_push,
	output cac_pkg::cmd_t              cmd,
	input  logic                       cmd_full
);
	import cac_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_SQ   = 2'd1;
	localparam logic [1:0] F_WR   = 2'd2;
	localparam logic [1:0] F_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic signed [15:0] re_q, im_q;
	logic              last_q;
	logic [31:0]       sqr_q, sqi_q;
	logic [WIN_AW-1:0] wr_ptr_q;
	logic [5:0]        seen_q;
	logic [5:0]        pend_q;
	logic signed [31:0] sqr, sqi;
	logic [5:0]        delay, age;
	logic              need;

	assign full  = (state_q != F_IDLE);
	assign sqr   = re_q * re_q;
	assign sqi   = im_q * im_q;
	assign delay = {1'b0, cfg.rc} + {2'b0, cfg.gc};
	assign age   = pend_q - 6'd1;
	assign need  = last_q ? (pend_q != '0) : (pend_q > delay);

	// window write
	assign ram_we    = (state_q == F_WR);
	assign ram_waddr = wr_ptr_q;
	assign ram_wdata = sqr_q + sqi_q;

	// emit command for the oldest pending cell
	assign cmd_push   = (state_q == F_EMIT) && need && !cmd_full;
	assign cmd.pos    = wr_ptr_q - WIN_AW'(1) - age[WIN_AW-1:0];
	assign cmd.lavail = seen_q - 6'd1 - age;
	assign cmd.ravail = age;
	assign cmd.last   = last_q && (pend_q == 6'd1);

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			wr_ptr_q <= '0;
			seen_q   <= '0;
			pend_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) state_q <= F_SQ;
				end
				F_SQ: begin
					state_q <= F_WR;
				end
				F_WR: begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
					if (seen_q != 6'd63) seen_q <= seen_q + 6'd1;
					pend_q  <= pend_q + 6'd1;
					state_q <= F_EMIT;
				end
				F_EMIT: begin
					if (need) begin
						if (!cmd_full) pend_q <= pend_q - 6'd1;
					end else begin
						if (last_q) seen_q <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			re_q   <= bin.bin_real;
			im_q   <= bin.bin_imag;
			last_q <= bin.frame_last;
		end
		if (state_q == F_SQ) begin
			sqr_q <= $unsigned(sqr);
			sqi_q <= $unsigned(sqi);
		end
	end
endmodule

/* design/cac_back.sv */
// back: sums reference cells, divides by count, scales by alpha
module cac_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cac_pkg::cfg_t              cfg,
	input  cac_pkg::cmd_t              cmd,
	input  logic                       cmd_empty,
	output logic                       cmd_pop,
	output logic [cac_pkg::WIN_AW-1:0] ram_raddr,
	input  logic [31:0]                ram_rdata,
	output cac_pkg::cell_t             result,
	output logic                       empty,
	input  logic                       pop
);
	import cac_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_RD   = 3'd1;
	localparam logic [2:0] B_DIV  = 3'd2;
	localparam logic [2:0] B_MUL  = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	logic [2:0]       state_q;
	cmd_t             cmd_q;
	logic [5:0]       k_q;
	logic [SUM_W-1:0] sum_q, quo_q;
	logic [5:0]       cnt_q, rem_q, dcnt_q;
	logic [31:0]      pow_q;
	logic             rd_v_s1, rd_ctr_s1, rd_use_s1;
	logic [THR_W-1:0] thr_q;
	cell_t            out_q;
	logic             out_v_q;
	logic [5:0]       kmax, j, off;
	logic             issue, left, use_ref;
	logic [6:0]       remsh;
	logic [SUM_W+15:0] prod;

	assign kmax    = {cfg.rc, 1'b0};
	assign issue   = (state_q == B_RD) && (k_q <= kmax);
	assign j       = (k_q + 6'd1) >> 1;
	assign left    = k_q[0];
	assign off     = {2'b0, cfg.gc} + j;
	assign use_ref = left ? (off <= cmd_q.lavail) : (off <= cmd_q.ravail);
	assign remsh   = {rem_q, quo_q[SUM_W-1]};
	assign prod    = quo_q * cfg.alpha;
	assign cmd_pop = (state_q == B_IDLE) && !cmd_empty;

	// read address: center, then left and right reference cells in turn
	always_comb begin
		if (k_q == '0)  ram_raddr = cmd_q.pos;
		else if (left)  ram_raddr = cmd_q.pos - off[WIN_AW-1:0];
		else            ram_raddr = cmd_q.pos + off[WIN_AW-1:0];
	end

	assign result = out_q;
	assign empty  = !out_v_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (pop && out_v_q) out_v_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!cmd_empty) state_q <= B_RD;
				end
				B_RD: begin
					if (!issue && !rd_v_s1) state_q <= B_DIV;
				end
				B_DIV: begin
					if (cnt_q == '0 || dcnt_q == 6'd1) state_q <= B_MUL;
				end
				B_MUL: begin
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		rd_ctr_s1 <= (k_q == '0);
		rd_use_s1 <= use_ref;
		case (state_q)
			B_IDLE: begin
				cmd_q <= cmd;
				k_q   <= '0;
				sum_q <= '0;
				cnt_q <= '0;
			end
			B_RD: begin
				if (issue) k_q <= k_q + 6'd1;
				// accumulate the beat read in the previous cycle
				if (rd_v_s1) begin
					if (rd_ctr_s1) begin
						pow_q <= ram_rdata;
					end else if (rd_use_s1) begin
						sum_q <= sum_q + SUM_W'(ram_rdata);
						cnt_q <= cnt_q + 6'd1;
					end
				end
				if (!issue && !rd_v_s1) begin
					quo_q  <= sum_q;
					rem_q  <= '0;
					dcnt_q <= 6'(SUM_W);
				end
			end
			B_DIV: begin
				// restoring division, one quotient bit a cycle
				if (cnt_q == '0) begin
					quo_q <= '0;
				end else begin
					dcnt_q <= dcnt_q - 6'd1;
					if (remsh >= {1'b0, cnt_q}) begin
						rem_q <= 6'(remsh - {1'b0, cnt_q});
						quo_q <= {quo_q[SUM_W-2:0], 1'b1};
					end else begin
						rem_q <= remsh[5:0];
						quo_q <= {quo_q[SUM_W-2:0], 1'b0};
					end
				end
			end
			B_MUL: begin
				thr_q <= prod[THR_W+7:8];
			end
			B_OUT: begin
				if (!out_v_q) begin
					out_q.cell_power      <= pow_q;
					out_q.noise_threshold <= thr_q;
					out_q.cell_last       <= cmd_q.last;
				end
			end
			default: ;
		endcase
	end
endmodule

/* design/ca_cfar_threshold.sv */
// top level of the cell averaging cfar threshold block
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------
//  bins in  | push / full      | bin   (bin_real, bin_imag, frame_last)
//  cells out| pop / empty      | result (cell_power, noise_threshold, cell_last)
//  config   | cfg_we           | cfg_index, cfg_data
//
// a bin passes the front as latch, square, window write and emit check; the emit
// check pushes one emitted cell per cycle into the command queue while it is not full.
// each cell passes the back as command take, window reads of the center and
// clamped reference cells on the single ram read port, bit-serial division (cut
// short when no reference cell exists), multiply and output.
// reset clears all control state; window contents need no clearing.
// a full command queue stalls the front, a waiting result stalls the back.
module ca_cfar_threshold (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cac_pkg::bin_t   bin,
	output logic            full,
	input  logic            pop,
	output cac_pkg::cell_t  result,
	output logic            empty,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);
	import cac_pkg::*;

	logic [4:0]        ref_q;
	logic [3:0]        guard_q;
	logic [15:0]       alpha_q;
	cfg_t              cfg;
	logic              ram_we;
	logic [WIN_AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]       ram_wdata, ram_rdata;
	logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t              cmd_in, cmd_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q   <= 5'd8;
			guard_q <= 4'd2;
			alpha_q <= 16'd768;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REF:   ref_q   <= cfg_data[4:0];
				CFG_GUARD: guard_q <= cfg_data[3:0];
				CFG_ALPHA: alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp oversized settings
	assign cfg.rc    = (ref_q > 5'(MAX_REF)) ? 5'(MAX_REF) : ref_q;
	assign cfg.gc    = (guard_q > 4'(MAX_GUARD)) ? 4'(MAX_GUARD) : guard_q;
	assign cfg.alpha = alpha_q;

	cac_front u_front (
		.clk, .arst_n, .cfg, .push, .bin, .full,
		.ram_we, .ram_waddr, .ram_wdata,
		.cmd_push, .cmd(cmd_in), .cmd_full
	);

	cac_cmd_fifo u_cmdq (
		.clk, .arst_n, .push(cmd_push), .din(cmd_in), .full(cmd_full),
		.pop(cmd_pop), .dout(cmd_out), .empty(cmd_empty)
	);

	cac_ram #(.WIDTH(32), .DEPTH(WIN_DEPTH)) u_win (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	cac_back u_back (
		.clk, .arst_n, .cfg, .cmd(cmd_out), .cmd_empty, .cmd_pop,
		.ram_raddr, .ram_rdata, .result, .empty, .pop
	);
endmodule

/* design/cac_checker.sv */
// port level checks for the cfar threshold block and their binding
module cac_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           push,
	input logic           full,
	input logic           pop,
	input logic           empty,
	input cac_pkg::cell_t result
);
	import cac_pkg::*;

	// a waiting result beat holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result beat changed while waiting");

	// an accepted bin keeps the front busy the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("front took a second bin too early");

	// leaving reset shows no result and an open input
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> empty && !full)
		else $error("block not clear after reset");

	// power of a cell never exceeds two to the 31
	a_pow: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.cell_power <= 32'h8000_0000)
		else $error("cell power out of range");
endmodule

bind ca_cfar_threshold cac_checker u_chk (
	.clk, .arst_n, .push, .full, .pop, .empty, .result
);
